// ===== rtl/core/pid_drive_controller_unit_assert.svh =====
// ----------------------------------------------------------------------------
// PID drive controller assertion macros
// Immediate-implication and next-cycle checks, compiled out with NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef PID_DRIVE_CONTROLLER_UNIT_ASSERT_SVH
`define PID_DRIVE_CONTROLLER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pdc: implication check failed");
// next-cycle implication
`define PDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pdc: next-cycle check failed");
`else
`define PDC_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define PDC_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

// ===== rtl/core/pdc_pkg.sv =====
// ----------------------------------------------------------------------------
// PID drive controller package
// Widths, register indexes, reset values and pipeline stage types.
// ----------------------------------------------------------------------------
package pdc_pkg;

    localparam int POS_W    = 30;   // input position fields
    localparam int SUM_W    = 32;   // sum of four encoders
    localparam int ERR_W    = 34;   // error in quarter degrees
    localparam int INTEG_W  = 32;   // integral accumulator
    localparam int DERIV_W  = 35;   // error difference
    localparam int GAIN_W   = 20;
    localparam int LIMIT_W  = 30;
    localparam int CFG_W    = 30;   // widest register
    localparam int CFG_IDX_W = 2;
    localparam int PROD_W   = 56;
    localparam int TOTAL_W  = 58;
    localparam int FRAC_SHIFT = 18;
    localparam int POWER_W  = 8;
    localparam int MAG_W    = 7;

    localparam logic [MAG_W-1:0] POWER_MAX = 7'd127;

    localparam logic [CFG_IDX_W-1:0] CFG_PROP_GAIN   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_GAIN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DERIV_GAIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT = 2'd3;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 20'd11633;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 20'd0;
    localparam logic [GAIN_W-1:0]  DERIV_GAIN_RST  = 20'd1163;
    localparam logic [LIMIT_W-1:0] INTEG_LIMIT_RST = 30'd20000;

    typedef logic signed [POS_W-1:0] t_pos;

    typedef struct packed {
        t_pos target_pos;
        t_pos left_enc_a;
        t_pos left_enc_b;
        t_pos right_enc_a;
        t_pos right_enc_b;
    } t_tick_item;

    typedef struct packed {
        logic                       zero;
        logic signed [ERR_W-1:0]    err;
        logic signed [INTEG_W-1:0]  integ;
        logic signed [DERIV_W-1:0]  deriv;
    } t_err_stage;

    typedef struct packed {
        logic                       zero;
        logic signed [PROD_W-1:0]   p_prop;
        logic signed [PROD_W-1:0]   p_integ;
        logic signed [PROD_W-1:0]   p_deriv;
    } t_prod_stage;

endpackage

// ===== rtl/core/pdc_tick_if.sv =====
// ----------------------------------------------------------------------------
// Tick request channel
// Target position and four encoder positions with valid/ready.
// ----------------------------------------------------------------------------
interface pdc_tick_if import pdc_pkg::*; ();
    logic valid;
    logic ready;
    t_pos target_pos;
    t_pos left_enc_a;
    t_pos left_enc_b;
    t_pos right_enc_a;
    t_pos right_enc_b;

    modport source (
        output valid, target_pos, left_enc_a, left_enc_b, right_enc_a, right_enc_b,
        input  ready
    );
    modport sink (
        input  valid, target_pos, left_enc_a, left_enc_b, right_enc_a, right_enc_b,
        output ready
    );
endinterface

// ===== rtl/core/pdc_drive_if.sv =====
// ----------------------------------------------------------------------------
// Drive result channel
// Saturated drive power and saturation flag with valid/ready.
// ----------------------------------------------------------------------------
interface pdc_drive_if import pdc_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [POWER_W-1:0] drive_power;
    logic                      power_saturated;

    modport source (
        output valid, drive_power, power_saturated,
        input  ready
    );
    modport sink (
        input  valid, drive_power, power_saturated,
        output ready
    );
endinterface

// ===== rtl/core/pdc_front.sv =====
// ----------------------------------------------------------------------------
// PID drive controller front end
// Input register, error, clamped integral, derivative and loop state.
// ----------------------------------------------------------------------------
`include "pid_drive_controller_unit_assert.svh"

module pdc_front import pdc_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pdc_tick_if.sink           i_tick,
    input  logic [LIMIT_W-1:0] i_integ_limit,
    output logic               o_valid,
    output t_err_stage         o_stage,
    input  logic               i_ready
);

    logic                        r_v1;
    t_tick_item                  r_item;
    logic                        r_v2;
    t_err_stage                  r_stage;
    logic signed [INTEG_W-1:0]   r_integ_accum;
    logic signed [ERR_W-1:0]     r_last_error;

    logic                        adv1;
    logic                        upd;
    logic signed [SUM_W-1:0]     enc_sum;
    logic signed [ERR_W-1:0]     tgt4;
    logic signed [ERR_W-1:0]     err;
    logic signed [DERIV_W-1:0]   integ_raw;
    logic signed [DERIV_W-1:0]   lim_ext;
    logic signed [INTEG_W-1:0]   lim_s;
    logic signed [INTEG_W-1:0]   n_integ_accum;
    t_err_stage                  n_stage;

    assign adv1         = r_v1 && (!r_v2 || i_ready);
    assign i_tick.ready = !r_v1 || adv1;

    always_comb begin
        enc_sum = SUM_W'(r_item.left_enc_a) + SUM_W'(r_item.left_enc_b)
                + SUM_W'(r_item.right_enc_a) + SUM_W'(r_item.right_enc_b);
        // target in quarter degrees
        tgt4    = ERR_W'($signed({r_item.target_pos, 2'b00}));
        err     = tgt4 - ERR_W'(enc_sum);

        lim_ext   = $signed({{(DERIV_W-LIMIT_W){1'b0}}, i_integ_limit});
        lim_s     = $signed({{(INTEG_W-LIMIT_W){1'b0}}, i_integ_limit});
        integ_raw = DERIV_W'(r_integ_accum) + DERIV_W'(err);
        if (integ_raw > lim_ext) begin
            n_integ_accum = lim_s;
        end else if (integ_raw < -lim_ext) begin
            n_integ_accum = -lim_s;
        end else begin
            n_integ_accum = INTEG_W'(integ_raw);
        end

        n_stage.zero  = (r_item.target_pos == '0);
        n_stage.err   = err;
        n_stage.integ = n_integ_accum;
        n_stage.deriv = DERIV_W'(err) - DERIV_W'(r_last_error);
    end

    // stopped ticks leave the loop state alone
    assign upd = adv1 && !n_stage.zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1          <= 1'b0;
            r_v2          <= 1'b0;
            r_integ_accum <= '0;
            r_last_error  <= '0;
        end else begin
            if (i_tick.ready) begin
                r_v1 <= i_tick.valid;
            end
            if (adv1) begin
                r_v2 <= 1'b1;
            end else if (i_ready) begin
                r_v2 <= 1'b0;
            end
            if (upd) begin
                r_integ_accum <= n_integ_accum;
                r_last_error  <= err;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_item.target_pos  <= i_tick.target_pos;
            r_item.left_enc_a  <= i_tick.left_enc_a;
            r_item.left_enc_b  <= i_tick.left_enc_b;
            r_item.right_enc_a <= i_tick.right_enc_a;
            r_item.right_enc_b <= i_tick.right_enc_b;
        end
        if (adv1) begin
            r_stage <= n_stage;
        end
    end

    assign o_valid = r_v2;
    assign o_stage = r_stage;

    `PDC_ASSERT_NEXT(a_state_hold, i_clk, i_rst_n, !upd, $stable(r_integ_accum) && $stable(r_last_error))
    `PDC_ASSERT_IMPL(a_integ_clamp, i_clk, i_rst_n, upd, (n_integ_accum <= lim_s) && (n_integ_accum >= -lim_s))

endmodule

// ===== rtl/core/pdc_mult.sv =====
// ----------------------------------------------------------------------------
// PID drive controller product stage
// Three gain multiplications into one registered stage.
// ----------------------------------------------------------------------------
module pdc_mult import pdc_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_err_stage        i_stage,
    output logic              o_ready,
    input  logic [GAIN_W-1:0] i_prop_gain,
    input  logic [GAIN_W-1:0] i_integ_gain,
    input  logic [GAIN_W-1:0] i_deriv_gain,
    output logic              o_valid,
    output t_prod_stage       o_prod,
    input  logic              i_ready
);

    logic                     r_v;
    t_prod_stage              r_prod;
    t_prod_stage              n_prod;
    logic signed [GAIN_W:0]   kp;
    logic signed [GAIN_W:0]   ki;
    logic signed [GAIN_W:0]   kd;
    logic                     adv;

    // full-width products, sized by assignment
    logic signed [ERR_W+GAIN_W:0]   prod_p;
    logic signed [INTEG_W+GAIN_W:0] prod_i;
    logic signed [DERIV_W+GAIN_W:0] prod_d;

    assign o_ready = !r_v || i_ready;
    assign adv     = i_valid && o_ready;

    always_comb begin
        kp = $signed({1'b0, i_prop_gain});
        ki = $signed({1'b0, i_integ_gain});
        kd = $signed({1'b0, i_deriv_gain});
        prod_p = i_stage.err * kp;
        prod_i = i_stage.integ * ki;
        prod_d = i_stage.deriv * kd;
        n_prod.zero    = i_stage.zero;
        n_prod.p_prop  = PROD_W'(prod_p);
        n_prod.p_integ = PROD_W'(prod_i);
        n_prod.p_deriv = PROD_W'(prod_d);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (o_ready) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_prod <= n_prod;
        end
    end

    assign o_valid = r_v;
    assign o_prod  = r_prod;

endmodule

// ===== rtl/core/pdc_out.sv =====
// ----------------------------------------------------------------------------
// PID drive controller output stage
// Term sum, scaling with truncation toward zero, saturation, result register.
// ----------------------------------------------------------------------------
`include "pid_drive_controller_unit_assert.svh"

module pdc_out import pdc_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  t_prod_stage   i_prod,
    output logic          o_ready,
    pdc_drive_if.source   o_drive
);

    logic                         r_v4;
    logic signed [TOTAL_W-1:0]    r_total;
    logic                         r_v5;
    logic signed [POWER_W-1:0]    r_power;
    logic                         r_sat;

    logic                         ready5;
    logic                         adv4;
    logic signed [TOTAL_W-1:0]    n_total;
    logic                         neg;
    logic [TOTAL_W-1:0]           mag;
    logic [TOTAL_W-FRAC_SHIFT-1:0] scaled;
    logic                         n_sat;
    logic [MAG_W-1:0]             mag_clip;
    logic signed [POWER_W-1:0]    n_power;

    assign ready5  = !r_v5 || o_drive.ready;
    assign adv4    = r_v4 && ready5;
    assign o_ready = !r_v4 || ready5;

    // stopped tick forces a zero sum: zero power, no saturation
    assign n_total = i_prod.zero ? '0
                   : TOTAL_W'(i_prod.p_prop) + TOTAL_W'(i_prod.p_integ)
                   + TOTAL_W'(i_prod.p_deriv);

    always_comb begin
        neg      = r_total[TOTAL_W-1];
        mag      = neg ? TOTAL_W'(-r_total) : TOTAL_W'(r_total);
        scaled   = mag[TOTAL_W-1:FRAC_SHIFT];
        n_sat    = |scaled[TOTAL_W-FRAC_SHIFT-1:MAG_W];
        mag_clip = n_sat ? POWER_MAX : scaled[MAG_W-1:0];
        n_power  = neg ? -$signed({1'b0, mag_clip}) : $signed({1'b0, mag_clip});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (o_ready) begin
                r_v4 <= i_valid;
            end
            if (adv4) begin
                r_v5 <= 1'b1;
            end else if (o_drive.ready) begin
                r_v5 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_total <= n_total;
        end
        if (adv4) begin
            r_power <= n_power;
            r_sat   <= n_sat;
        end
    end

    assign o_drive.valid           = r_v5;
    assign o_drive.drive_power     = r_power;
    assign o_drive.power_saturated = r_sat;

    `PDC_ASSERT_IMPL(a_sat_full_scale, i_clk, i_rst_n, r_v5 && r_sat, (r_power == 8'sd127) || (r_power == -8'sd127))

endmodule

// ===== rtl/core/pid_drive_controller_unit.sv =====
// ----------------------------------------------------------------------------
// PID drive controller unit
// Clamped-integral PID position loop for a four-motor drive.
// ----------------------------------------------------------------------------
// Usage:
//   i_tick carries one request per control tick: target position and four
//   encoder positions, all in degrees. o_drive returns one result per request:
//   drive power in -127..127 and a flag set when the power was clipped. A zero
//   target gives zero power and leaves the loop state untouched. Gains and the
//   integral limit are written on the cfg port (index 0 prop, 1 integ, 2 deriv,
//   3 limit); user must only write them with no request in flight (unchecked).
// Timing:
//   Five register stages: input, error/integral, products, term sum, result.
//   One request per cycle is sustained while the receiver keeps o_drive.ready
//   high; the loop state (integral and last error) updates in the error stage,
//   so each request sees the state left by the requests before it.
// Reset and stall:
//   Synchronous reset empties the pipeline, clears the integral and last error
//   and restores the register defaults. If the receiver stalls, each stage
//   holds its data and i_tick.ready drops once every stage is full.
// ----------------------------------------------------------------------------
module pid_drive_controller_unit import pdc_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    pdc_tick_if.sink             i_tick,
    pdc_drive_if.source          o_drive,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    // configuration registers
    logic [GAIN_W-1:0]  r_prop_gain;
    logic [GAIN_W-1:0]  r_integ_gain;
    logic [GAIN_W-1:0]  r_deriv_gain;
    logic [LIMIT_W-1:0] r_integ_limit;

    // stage handshakes
    logic        err_valid;
    logic        err_ready;
    t_err_stage  err_stage;
    logic        prod_valid;
    logic        prod_ready;
    t_prod_stage prod_stage;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prop_gain   <= PROP_GAIN_RST;
            r_integ_gain  <= INTEG_GAIN_RST;
            r_deriv_gain  <= DERIV_GAIN_RST;
            r_integ_limit <= INTEG_LIMIT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_PROP_GAIN:   r_prop_gain   <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_GAIN:  r_integ_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_DERIV_GAIN:  r_deriv_gain  <= i_cfg_data[GAIN_W-1:0];
                CFG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    // error, clamped integral, derivative; holds the loop state
    pdc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_tick        (i_tick),
        .i_integ_limit (r_integ_limit),
        .o_valid       (err_valid),
        .o_stage       (err_stage),
        .i_ready       (err_ready)
    );

    // gain products
    pdc_mult u_mult (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (err_valid),
        .i_stage      (err_stage),
        .o_ready      (err_ready),
        .i_prop_gain  (r_prop_gain),
        .i_integ_gain (r_integ_gain),
        .i_deriv_gain (r_deriv_gain),
        .o_valid      (prod_valid),
        .o_prod       (prod_stage),
        .i_ready      (prod_ready)
    );

    // sum, Q16 plus quarter-degree scaling (>> 18), saturation, result register
    pdc_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (prod_valid),
        .i_prod  (prod_stage),
        .o_ready (prod_ready),
        .o_drive (o_drive)
    );

endmodule

// ===== bench/tb_pid_drive_controller_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// PID drive controller unit testbench
// A stimulus table, then random tick requests over several gain and limit
// settings. Each result is checked against its row's typed value or a
// cycle-free model of the clamped-integral PID loop that the bench keeps itself.
// ----------------------------------------------------------------------------
module tb_pid_drive_controller_unit;
    import pdc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 8;
    localparam int PHASE_REQS  = 160;
    localparam int GAIN_MAX    = 1048575;
    localparam int LIMIT_MAX   = 1073741823;
    localparam int POS_MAX     = 536870911;
    localparam int POS_MIN     = -536870912;

    // one expected drive result
    typedef struct packed {
        logic signed [POWER_W-1:0] power;
        logic                      sat;
    } t_drive_exp;

    typedef enum logic {ROW_TICK, ROW_CFG} t_row_kind;

    // directed stimulus row; want_* is used only where typed is set
    typedef struct {
        t_row_kind            kind;
        int                   tgt;
        int                   la;
        int                   lb;
        int                   ra;
        int                   rb;
        logic [CFG_IDX_W-1:0] reg_idx;
        int unsigned          reg_val;
        bit                   typed;
        int                   want_power;
        bit                   want_sat;
    } t_stim_row;

    localparam int DIR_ROWS = 23;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    pdc_tick_if  tick_ch ();
    pdc_drive_if drive_ch ();

    pid_drive_controller_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick_ch),
        .o_drive     (drive_ch),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // loop model: register copies and state
    logic [GAIN_W-1:0]  kp_q16;
    logic [GAIN_W-1:0]  ki_q16;
    logic [GAIN_W-1:0]  kd_q16;
    logic [LIMIT_W-1:0] integ_bound;
    longint             integ_acc;
    longint             err_prev;

    t_drive_exp pending_drive [$];
    int         mismatch_count = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         tx_steady = 1'b0;
    bit         rx_steady = 1'b0;

    // Directed table. Rows with typed results are the ones readable by eye:
    // zero target, full-scale saturation either way. The rest go to the model.
    t_stim_row dir_table [DIR_ROWS] = '{
        // zero target straight after reset
        '{ROW_TICK, 0, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b1, 0, 1'b0},
        // largest positive error, clips high
        '{ROW_TICK, POS_MAX, POS_MIN, POS_MIN, POS_MIN, POS_MIN, CFG_PROP_GAIN, 0,
          1'b1, 127, 1'b1},
        // largest negative error, clips low
        '{ROW_TICK, POS_MIN, POS_MAX, POS_MAX, POS_MAX, POS_MAX, CFG_PROP_GAIN, 0,
          1'b1, -127, 1'b1},
        // zero target ignores wild encoders and holds state
        '{ROW_TICK, 0, POS_MAX, POS_MIN, POS_MAX, POS_MIN, CFG_PROP_GAIN, 0,
          1'b1, 0, 1'b0},
        // small errors: fractional power truncates toward zero
        '{ROW_TICK, 1, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        '{ROW_TICK, -1, 1, -1, 2, -2, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        '{ROW_TICK, 100, 99, 101, 100, 100, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        '{ROW_TICK, 200, 150, 160, 170, 180, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        // max P and I, no D, zero limit: integral pinned at zero
        '{ROW_CFG, 0, 0, 0, 0, 0, CFG_PROP_GAIN, GAIN_MAX, 1'b0, 0, 1'b0},
        '{ROW_CFG, 0, 0, 0, 0, 0, CFG_INTEG_GAIN, GAIN_MAX, 1'b0, 0, 1'b0},
        '{ROW_CFG, 0, 0, 0, 0, 0, CFG_DERIV_GAIN, 0, 1'b0, 0, 1'b0},
        '{ROW_CFG, 0, 0, 0, 0, 0, CFG_INTEG_LIMIT, 0, 1'b0, 0, 1'b0},
        '{ROW_TICK, 3, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        '{ROW_TICK, -3, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        // integral only, wide limit: watch it build up
        '{ROW_CFG, 0, 0, 0, 0, 0, CFG_INTEG_LIMIT, LIMIT_MAX, 1'b0, 0, 1'b0},
        '{ROW_CFG, 0, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        '{ROW_TICK, 10, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        '{ROW_TICK, 10, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        // tight limit: integral clamps to +limit then to -limit
        '{ROW_CFG, 0, 0, 0, 0, 0, CFG_INTEG_LIMIT, 50, 1'b0, 0, 1'b0},
        '{ROW_TICK, 10, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        '{ROW_TICK, -100, 0, 0, 0, 0, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0},
        // full derivative gain on a sign flip of the error
        '{ROW_CFG, 0, 0, 0, 0, 0, CFG_DERIV_GAIN, GAIN_MAX, 1'b0, 0, 1'b0},
        '{ROW_TICK, 7, 5, 6, 7, 8, CFG_PROP_GAIN, 0, 1'b0, 0, 1'b0}
    };

    task automatic report_mismatch(input string msg);
        $display("%0d ns mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // One control tick of the loop. Updates the integral and last error
    // unless the target is zero.
    function automatic t_drive_exp compute_drive(input t_tick_item it);
        longint     tgt;
        longint     enc_sum;
        longint     err;
        longint     integ;
        longint     slope;
        longint     total;
        longint     mag;
        t_drive_exp res;
        res.power = '0;
        res.sat   = 1'b0;
        tgt = longint'(it.target_pos);
        if (tgt == 0)
            return res;
        enc_sum = longint'(it.left_enc_a) + longint'(it.left_enc_b)
                + longint'(it.right_enc_a) + longint'(it.right_enc_b);
        err   = 4 * tgt - enc_sum;                  // quarter degrees
        integ = integ_acc + err;
        if (integ > longint'(integ_bound))
            integ = longint'(integ_bound);
        else if (integ < -longint'(integ_bound))
            integ = -longint'(integ_bound);
        slope     = err - err_prev;
        integ_acc = integ;
        err_prev  = err;
        total = err * longint'(kp_q16) + integ * longint'(ki_q16)
              + slope * longint'(kd_q16);
        // truncate toward zero, then saturate
        mag = (total < 0) ? -total : total;
        mag = mag >> FRAC_SHIFT;
        if (mag > 127) begin
            mag     = 127;
            res.sat = 1'b1;
        end
        res.power = POWER_W'((total < 0) ? -mag : mag);
        return res;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        if (steady)
            return 0;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(40, 8);
    endfunction

    function automatic int unsigned pick_gain();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? GAIN_MAX : 0;
            1: return $urandom_range(4096);
            2: return $urandom_range(65535);
            default: return $urandom_range(GAIN_MAX);
        endcase
    endfunction

    function automatic int unsigned pick_limit();
        case ($urandom_range(3))
            0: return $urandom_range(1) ? LIMIT_MAX : 0;
            1: return $urandom_range(100000);
            2: return $urandom_range(5000000);
            default: return $urandom_range(LIMIT_MAX);
        endcase
    endfunction

    // Mostly targets with encoders clustered around them, so the loop runs in
    // its linear range; some zero targets and some raw full-width noise.
    function automatic t_tick_item make_tick();
        t_tick_item it;
        int         sel;
        int         tgt;
        int         span;
        sel = $urandom_range(99);
        if (sel < 10) begin
            it.target_pos  = '0;
            it.left_enc_a  = t_pos'($urandom());
            it.left_enc_b  = t_pos'($urandom());
            it.right_enc_a = t_pos'($urandom());
            it.right_enc_b = t_pos'($urandom());
        end else if (sel < 30) begin
            it.target_pos  = t_pos'($urandom());
            it.left_enc_a  = t_pos'($urandom());
            it.left_enc_b  = t_pos'($urandom());
            it.right_enc_a = t_pos'($urandom());
            it.right_enc_b = t_pos'($urandom());
        end else begin
            tgt = int'($urandom_range(200000)) - 100000;
            case ($urandom_range(2))
                0: span = 30;
                1: span = 300;
                default: span = 3000;
            endcase
            it.target_pos  = t_pos'(tgt);
            it.left_enc_a  = t_pos'(tgt + int'($urandom_range(2 * span)) - span);
            it.left_enc_b  = t_pos'(tgt + int'($urandom_range(2 * span)) - span);
            it.right_enc_a = t_pos'(tgt + int'($urandom_range(2 * span)) - span);
            it.right_enc_b = t_pos'(tgt + int'($urandom_range(2 * span)) - span);
        end
        return it;
    endfunction

    // Called at a falling edge, returns at a falling edge with valid still
    // high so the next request can follow back to back.
    task automatic send_tick(input t_tick_item it, input bit typed,
                             input t_drive_exp typed_res);
        int         gap;
        t_drive_exp res;
        gap = pick_gap(tx_steady);
        if (gap > 0) begin
            tick_ch.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid       = 1'b1;
        tick_ch.target_pos  = it.target_pos;
        tick_ch.left_enc_a  = it.left_enc_a;
        tick_ch.left_enc_b  = it.left_enc_b;
        tick_ch.right_enc_a = it.right_enc_a;
        tick_ch.right_enc_b = it.right_enc_b;
        do @(posedge i_clk); while (!tick_ch.ready);
        res = compute_drive(it);
        pending_drive.push_back(typed ? typed_res : res);
        @(negedge i_clk);
    endtask

    // Drop valid and wait for every result to come back: pipeline is empty.
    task automatic quiesce();
        tick_ch.valid = 1'b0;
        while (pending_drive.size() != 0)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Called at a falling edge with the pipeline empty.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = CFG_W'(val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_PROP_GAIN:   kp_q16      = GAIN_W'(val);
            CFG_INTEG_GAIN:  ki_q16      = GAIN_W'(val);
            CFG_DERIV_GAIN:  kd_q16      = GAIN_W'(val);
            CFG_INTEG_LIMIT: integ_bound = LIMIT_W'(val);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    // Receiver: ready changes at the falling edge, runs of ready broken by
    // stalls of random length.
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            drive_ch.ready = 1'b0;
            stall_left--;
        end else begin
            drive_ch.ready = 1'b1;
            stall_left = pick_gap(rx_steady);
        end
    end

    // Result check, sampled at the rising edge.
    always @(posedge i_clk) begin : drive_check
        t_drive_exp want;
        if (i_rst_n && drive_ch.valid && drive_ch.ready) begin
            if (pending_drive.size() == 0) begin
                report_mismatch($sformatf("drive result %0d/%0b with no request pending",
                                          drive_ch.drive_power, drive_ch.power_saturated));
            end else begin
                want = pending_drive.pop_front();
                if (drive_ch.drive_power !== want.power)
                    report_mismatch($sformatf("drive_power got %0d want %0d",
                                              drive_ch.drive_power, want.power));
                if (drive_ch.power_saturated !== want.sat)
                    report_mismatch($sformatf("power_saturated got %0b want %0b",
                                              drive_ch.power_saturated, want.sat));
            end
        end
    end

    // Hard stop if the handshakes ever hang.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_drive.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin : stimulus
        t_tick_item it;
        t_drive_exp typed_res;
        i_rst_n             = 1'b0;
        i_cfg_we            = 1'b0;
        i_cfg_index         = CFG_PROP_GAIN;
        i_cfg_data          = '0;
        tick_ch.valid       = 1'b0;
        tick_ch.target_pos  = '0;
        tick_ch.left_enc_a  = '0;
        tick_ch.left_enc_b  = '0;
        tick_ch.right_enc_a = '0;
        tick_ch.right_enc_b = '0;
        drive_ch.ready      = 1'b0;

        // model state as after reset
        kp_q16      = PROP_GAIN_RST;
        ki_q16      = INTEG_GAIN_RST;
        kd_q16      = DERIV_GAIN_RST;
        integ_bound = INTEG_LIMIT_RST;
        integ_acc   = 0;
        err_prev    = 0;

        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed table
        foreach (dir_table[i]) begin
            if (dir_table[i].kind == ROW_CFG) begin
                quiesce();
                write_reg(dir_table[i].reg_idx, dir_table[i].reg_val);
            end else begin
                it.target_pos  = t_pos'(dir_table[i].tgt);
                it.left_enc_a  = t_pos'(dir_table[i].la);
                it.left_enc_b  = t_pos'(dir_table[i].lb);
                it.right_enc_a = t_pos'(dir_table[i].ra);
                it.right_enc_b = t_pos'(dir_table[i].rb);
                typed_res.power = POWER_W'(dir_table[i].want_power);
                typed_res.sat   = dir_table[i].want_sat;
                send_tick(it, dir_table[i].typed, typed_res);
            end
        end

        // Random phases. The first three pin the settings: reset defaults,
        // everything at maximum, everything at zero. The rest are drawn.
        typed_res = '0;
        for (int phase = 0; phase < PHASES; phase++) begin
            quiesce();
            case (phase)
                0: begin
                    write_reg(CFG_PROP_GAIN, PROP_GAIN_RST);
                    write_reg(CFG_INTEG_GAIN, INTEG_GAIN_RST);
                    write_reg(CFG_DERIV_GAIN, DERIV_GAIN_RST);
                    write_reg(CFG_INTEG_LIMIT, INTEG_LIMIT_RST);
                end
                1: begin
                    write_reg(CFG_PROP_GAIN, GAIN_MAX);
                    write_reg(CFG_INTEG_GAIN, GAIN_MAX);
                    write_reg(CFG_DERIV_GAIN, GAIN_MAX);
                    write_reg(CFG_INTEG_LIMIT, LIMIT_MAX);
                end
                2: begin
                    write_reg(CFG_PROP_GAIN, 0);
                    write_reg(CFG_INTEG_GAIN, 0);
                    write_reg(CFG_DERIV_GAIN, 0);
                    write_reg(CFG_INTEG_LIMIT, 0);
                end
                default: begin
                    write_reg(CFG_PROP_GAIN, pick_gain());
                    write_reg(CFG_INTEG_GAIN, pick_gain());
                    write_reg(CFG_DERIV_GAIN, pick_gain());
                    write_reg(CFG_INTEG_LIMIT, pick_limit());
                end
            endcase
            // some phases run flat out on one side or both
            tx_steady = ($urandom_range(3) == 0);
            rx_steady = ($urandom_range(3) == 0);
            for (int n = 0; n < PHASE_REQS; n++)
                send_tick(make_tick(), 1'b0, typed_res);
        end

        // drain, then give the pipeline time to show any stray result
        tx_steady = 1'b0;
        rx_steady = 1'b0;
        quiesce();
        repeat (12) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
